@@ hdl/mlbc_pkg.sv @@
// Shared types, codes and constants for the multi-LED blink controller.
`default_nettype none

package mlbc_pkg;

  localparam int NUM_LEDS_DEF = 8;
  localparam int PIN_W        = 8;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int TICK_W       = 17;
  localparam int PERIOD_W     = 16;
  localparam int DUTY_W       = 7;
  localparam int COUNT_W      = 8;

  localparam logic [DUTY_W-1:0]  DUTY_MAX      = 7'd100;
  localparam logic [COUNT_W-1:0] COUNT_FOREVER = 8'd255;
  localparam logic [TICK_W-1:0]  TICK_MAX      = 17'h1FFFF;

  // request kinds
  localparam logic [1:0] REQ_SET   = 2'd0;
  localparam logic [1:0] REQ_BLINK = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // set modes; anything else means off
  localparam logic [1:0] MODE_ON     = 2'd1;
  localparam logic [1:0] MODE_TOGGLE = 2'd2;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEDS_IN_USE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENT     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HIGH = 2'd3;

  // one slot of blink state
  typedef struct packed {
    logic [COUNT_W-1:0]  cycles;
    logic [DUTY_W-1:0]   duty;
    logic [PERIOD_W-1:0] period;
    logic [TICK_W-1:0]   tick;
  } entry_t;

  // tick engine result for one slot
  typedef struct packed {
    logic   valid;
    logic   active;
    logic   lit;
    entry_t nxt;
  } tick_res_t;

endpackage

`default_nettype wire

@@ hdl/mlbc_slot_mem.sv @@
// Per-slot blink state memory with reset-cleared valid bits and registered read.
`default_nettype none

module mlbc_slot_mem import mlbc_pkg::*; #(
  parameter int DEPTH = NUM_LEDS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire logic          clr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire entry_t        wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output entry_t             rd_data
);

  entry_t           mem [DEPTH];
  logic [DEPTH-1:0] valid;
  entry_t           mem_q;
  logic             valid_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end else if (clr_en) begin
        valid[wr_addr] <= 1'b0;
      end
      valid_q <= valid[rd_addr];
    end
  end

  // an entry never written, or cleared by a set, reads as idle
  assign rd_data = valid_q ? mem_q : '0;

endmodule

`default_nettype wire

@@ hdl/mlbc_tick_unit.sv @@
// Tick arithmetic for one slot: multiply stage, then compare and update.
`default_nettype none

module mlbc_tick_unit import mlbc_pkg::*; #(
  parameter int AW = 3
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic [AW-1:0]       in_addr,
  input  wire entry_t              in_entry,
  input  wire logic [PERIOD_W-1:0] tick_period,
  output tick_res_t                res,
  output logic [AW-1:0]            res_addr
);

  localparam int ELAPSED_W = TICK_W + PERIOD_W;
  localparam int HIGH_W    = PERIOD_W + DUTY_W;
  localparam int SCALED_W  = ELAPSED_W + 7;

  logic                 s2_valid;
  logic [AW-1:0]        s2_addr;
  entry_t               s2_entry;
  logic [ELAPSED_W-1:0] elapsed;
  logic [HIGH_W-1:0]    high_x100;

  logic [SCALED_W-1:0]  elapsed_ext;
  logic [SCALED_W-1:0]  scaled;
  logic                 period_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_addr   <= in_addr;
    s2_entry  <= in_entry;
    elapsed   <= ELAPSED_W'(in_entry.tick * tick_period);
    high_x100 <= HIGH_W'(in_entry.period * in_entry.duty);
  end

  // elapsed < floor(p*d/100)  <=>  100*(elapsed+1) <= p*d
  assign elapsed_ext = SCALED_W'(elapsed);
  assign scaled      = (elapsed_ext << 6) + (elapsed_ext << 5) + (elapsed_ext << 2)
                       + SCALED_W'(100);
  assign period_done = elapsed >= ELAPSED_W'(s2_entry.period);

  always_comb begin
    res.valid  = s2_valid;
    res.active = s2_entry.cycles != '0;
    res.lit    = scaled <= SCALED_W'(high_x100);
    res.nxt    = s2_entry;
    if (s2_entry.tick != TICK_MAX) begin
      res.nxt.tick = s2_entry.tick + 1'b1;
    end
    if (period_done) begin
      res.nxt.tick = '0;
      if (s2_entry.cycles != COUNT_FOREVER) begin
        res.nxt.cycles = s2_entry.cycles - 1'b1;
      end
    end
  end

  assign res_addr = s2_addr;

endmodule

`default_nettype wire

@@ hdl/multi_led_blink_controller_core.sv @@
// Multi-LED blink controller top level: request sequencer, pins and result register.
//
//   channel  dir  beat contents
//   s_*      in   tuser = req_type; tdata = led_index, set_mode, blink_count,
//                 duty_percent, blink_period_ms (low bit up)
//   m_*      out  tdata = led_pins; tuser = rejected
//   cfg_*    in   write enable, register index, write data
//
// Set, blink and unknown requests pass the apply and done states before the result.
// A tick reads min(leds_in_use, NUM_LEDS) slots, one slot memory read per
// cycle feeding a two-stage multiply/compare pipeline with write-back.
// One request is in flight at a time; a new one is taken while the last
// result still waits on m_tready. Reset clears slot valid bits at once.
`default_nettype none

module multi_led_blink_controller_core import mlbc_pkg::*; #(
  parameter int NUM_LEDS = NUM_LEDS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [39:0]          s_tdata,   // led_index[2:0], set_mode[4:3],
                                               // blink_count[12:5], duty_percent[20:13],
                                               // blink_period_ms[36:21], zero pad
  input  wire logic [1:0]           s_tuser,   // req_type[1:0]
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [PIN_W-1:0]          m_tdata,   // led_pins[7:0]
  output logic                      m_tuser,   // rejected[0]
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int AW    = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int CNT_W = $clog2(NUM_LEDS + 1);
  localparam int LIM_W = (CNT_W > 4) ? CNT_W : 4;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_APPLY = 2'd1;
  localparam logic [1:0] ST_TICK  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]  state;
  logic [1:0]  state_next;

  // config registers
  logic [PERIOD_W-1:0] tick_period;
  logic [3:0]          leds_in_use;
  logic [PIN_W-1:0]    present_mask;
  logic [PIN_W-1:0]    active_high;

  // captured request
  logic [1:0]          req_q;
  logic [2:0]          idx_q;
  logic [1:0]          mode_q;
  logic [COUNT_W-1:0]  count_q;
  logic [7:0]          duty_q;
  logic [PERIOD_W-1:0] period_q;

  logic [PIN_W-1:0]    pins;
  logic                rej_q;

  logic [LIM_W-1:0]    cnt;
  logic [LIM_W-1:0]    limit;
  logic                rd_issue;
  logic                s1_valid;
  logic [AW-1:0]       s1_addr;

  logic                mem_we;
  logic                mem_clr;
  logic [AW-1:0]       mem_waddr;
  entry_t              mem_wdata;
  entry_t              mem_rdata;

  tick_res_t           tres;
  logic [AW-1:0]       tres_addr;

  logic                idx_ok;
  logic [PIN_W-1:0]    idx_bit;
  logic                set_lit;
  logic                tick_drive;
  logic [2:0]          tick_bit;
  logic                out_free;

  mlbc_slot_mem #(.DEPTH(NUM_LEDS), .AW(AW)) u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (mem_we),
    .clr_en  (mem_clr),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (cnt[AW-1:0]),
    .rd_data (mem_rdata)
  );

  mlbc_tick_unit #(.AW(AW)) u_tick (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s1_valid),
    .in_addr     (s1_addr),
    .in_entry    (mem_rdata),
    .tick_period (tick_period),
    .res         (tres),
    .res_addr    (tres_addr)
  );

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  assign limit    = (LIM_W'(leds_in_use) < LIM_W'(NUM_LEDS)) ? LIM_W'(leds_in_use)
                                                              : LIM_W'(NUM_LEDS);
  assign rd_issue = (state == ST_TICK) && (cnt < limit);

  assign idx_ok  = (4'(idx_q) < leds_in_use) && (LIM_W'(idx_q) < LIM_W'(NUM_LEDS))
                   && present_mask[idx_q];
  assign idx_bit = PIN_W'(1) << idx_q;
  assign set_lit = (mode_q == MODE_ON);

  // slots past the pin vector never hold an active blink, but guard the index
  assign tick_bit   = 3'(tres_addr);
  assign tick_drive = tres.valid && tres.active && (LIM_W'(tres_addr) < LIM_W'(PIN_W))
                      && present_mask[tick_bit];

  always_comb begin
    mem_we    = 1'b0;
    mem_clr   = 1'b0;
    mem_waddr = AW'(idx_q);
    mem_wdata = '0;
    if (state == ST_APPLY && idx_ok) begin
      mem_clr             = (req_q == REQ_SET);
      mem_we              = (req_q == REQ_BLINK);
      mem_wdata.cycles    = count_q;
      mem_wdata.duty      = (duty_q > 8'(DUTY_MAX)) ? DUTY_MAX : duty_q[DUTY_W-1:0];
      mem_wdata.period    = period_q;
    end else if (state == ST_TICK && tres.valid && tres.active) begin
      mem_we    = 1'b1;
      mem_waddr = tres_addr;
      mem_wdata = tres.nxt;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (s_tuser == REQ_TICK) ? ST_TICK : ST_APPLY;
        end
      end
      ST_APPLY: state_next = ST_DONE;
      ST_TICK: begin
        if (!rd_issue && !s1_valid && !tres.valid) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      tick_period  <= 16'd10;
      leds_in_use  <= 4'd8;
      present_mask <= 8'hFF;
      active_high  <= 8'hFF;
      pins         <= '0;
      cnt          <= '0;
      s1_valid     <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      state    <= state_next;
      s1_valid <= rd_issue;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TICK_PERIOD: tick_period  <= cfg_data;
          CFG_LEDS_IN_USE: leds_in_use  <= cfg_data[3:0];
          CFG_PRESENT:     present_mask <= cfg_data[PIN_W-1:0];
          CFG_ACTIVE_HIGH: active_high  <= cfg_data[PIN_W-1:0];
          default: ;
        endcase
      end

      if (s_tvalid && s_tready) begin
        cnt <= '0;
      end else if (rd_issue) begin
        cnt <= cnt + 1'b1;
      end

      if (state == ST_APPLY && req_q == REQ_SET && idx_ok) begin
        if (mode_q == MODE_TOGGLE) begin
          pins <= pins ^ idx_bit;
        end else if (active_high[idx_q] == set_lit) begin
          pins <= pins | idx_bit;
        end else begin
          pins <= pins & ~idx_bit;
        end
      end else if (state == ST_TICK && tick_drive) begin
        pins[tick_bit] <= active_high[tick_bit] ? tres.lit : !tres.lit;
      end

      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    s1_addr <= cnt[AW-1:0];
    if (s_tvalid && s_tready) begin
      req_q    <= s_tuser;
      idx_q    <= s_tdata[2:0];
      mode_q   <= s_tdata[4:3];
      count_q  <= s_tdata[12:5];
      duty_q   <= s_tdata[20:13];
      period_q <= s_tdata[36:21];
      rej_q    <= 1'b0;
    end
    if (state == ST_APPLY) begin
      case (req_q) inside
        REQ_SET, REQ_BLINK: rej_q <= !idx_ok;
        REQ_TICK:           rej_q <= 1'b0;
        default:            rej_q <= 1'b1;
      endcase
    end
    if (state == ST_DONE && out_free) begin
      m_tdata <= pins;
      m_tuser <= rej_q;
    end
  end

`ifndef NO_ASSERTIONS
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while another is in flight");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !mem_we && !mem_clr)
    else $error("slot memory written while idle");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_DONE)
    else $error("result raised outside completion state");

  a_tick_drained: assert property (@(posedge clk) disable iff (rst)
    state == ST_TICK && state_next == ST_DONE |-> !s1_valid && !tres.valid)
    else $error("tick finished with slots still in the pipeline");
`endif

endmodule

`default_nettype wire
